// ===== rtl/tcw_pkg.sv =====
// Shared types, constants and codes of the text console writer.
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    typedef enum logic [2:0] {
        CMD_PUT_CHAR   = 3'd0,
        CMD_CLEAR      = 3'd1,
        CMD_SET_CURSOR = 3'd2,
        CMD_PUT_CELL   = 3'd3,
        CMD_READ_CELL  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_BSWR,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_OUT_CR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] row_pos;
        logic [COL_W-1:0] col_pos;
        logic [7:0]       cell_attr;
    } item_t;

    typedef struct packed {
        logic             serial_valid;
        logic [7:0]       serial_byte;
        logic             last;
        logic [ROW_W-1:0] row_after;
        logic [COL_W-1:0] col_after;
        logic [7:0]       read_char;
        logic [7:0]       read_attr;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_ctl_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: command sequencer, cursor and serial mirror.
//
//   channel   direction  handshake                  word
//   item      in         item_valid / item_ready     item_t command
//   result    out        result_valid / result_ready result_t status and serial byte
//   cfg       in         cfg_valid / cfg_ready       8-bit text attribute
//
// After reset a clearing pass writes all 2000 cells, one per cycle, before the first item.
// A newline gives two result words, a carriage return and then the newline; other commands give one.
// A clear walks all 2000 cells; a scroll copies 1920 cells and blanks 80, one per cycle,
// limited by the single write port of the screen store.
// The block takes one item at a time, holds its result until it is taken, and takes a new
// attribute only while idle.
module text_console_writer import tcw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    state_t            state_reg, state_next;
    item_t             item_reg;
    logic [7:0]        attr_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              copy_pend_reg, copy_pend_next;
    logic [ADDR_W-1:0] copy_addr_reg, copy_addr_next;
    logic [7:0]        rd_char_reg, rd_char_next;
    logic [7:0]        rd_attr_reg, rd_attr_next;

    logic              is_nl, is_bs, pos_ok, wrap, ptr_last, copy_last;
    logic [COL_W-1:0]  col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic              row_over;
    logic [ROW_W-1:0]  unit_row;
    logic [COL_W-1:0]  unit_col;
    logic [ADDR_W-1:0] unit_addr;
    mem_ctl_t          mem_ctl;
    logic [15:0]       rdata;

    tcw_screen_mem u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .rdata (rdata)
    );

    assign is_nl     = (item_reg.char_code == CHAR_NL);
    assign is_bs     = (item_reg.char_code == CHAR_BS);
    assign pos_ok    = (item_reg.row_pos < ROW_W'(ROWS)) && (item_reg.col_pos < COL_W'(COLS));
    assign col_inc   = col_reg + COL_W'(1);
    assign row_inc   = row_reg + ROW_W'(1);
    assign row_over  = (row_inc >= ROW_W'(ROWS));
    assign wrap      = is_nl || (col_inc >= COL_W'(COLS));
    assign ptr_last  = (ptr_reg == ADDR_W'(CELLS - 1));
    assign copy_last = (ptr_reg == ADDR_W'(CELLS - COLS - 1));

    // The shared address unit turns a row and column into a cell index.
    always_comb
    begin
        if (state_reg == ST_EXEC && item_reg.cmd != CMD_PUT_CHAR)
        begin
            unit_row = item_reg.row_pos;
            unit_col = item_reg.col_pos;
        end
        else
        begin
            unit_row = row_reg;
            unit_col = col_reg;
        end
        unit_addr = ADDR_W'(unit_row) * ADDR_W'(COLS) + ADDR_W'(unit_col);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (ptr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (item_reg.cmd)
                    CMD_PUT_CHAR:
                    begin
                        if (is_bs)
                        begin
                            state_next = ST_BSWR;
                        end
                        else if (wrap && row_over)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else if (is_nl)
                        begin
                            state_next = ST_OUT_CR;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    CMD_CLEAR:     state_next = ST_BLANK;
                    CMD_READ_CELL: state_next = ST_READ;
                    default:       state_next = ST_OUT;
                endcase
            end
            ST_BSWR:   state_next = ST_OUT;
            ST_READ:   state_next = ST_OUT;
            ST_SCROLL:
            begin
                if (copy_last)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (ptr_last && !copy_pend_reg)
                begin
                    if (item_reg.cmd == CMD_PUT_CHAR && is_nl)
                    begin
                        state_next = ST_OUT_CR;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT_CR:
            begin
                if (result_ready)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        ptr_next       = ptr_reg;
        copy_pend_next = 1'b0;
        copy_addr_next = ptr_reg;
        rd_char_next   = rd_char_reg;
        rd_attr_next   = rd_attr_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                ptr_next = ptr_last ? '0 : ptr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                ptr_next = '0;
            end
            ST_EXEC:
            begin
                rd_char_next = '0;
                rd_attr_next = '0;
                unique case (item_reg.cmd)
                    CMD_PUT_CHAR:
                    begin
                        if (is_bs)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - COL_W'(1);
                            end
                            else if (row_reg != '0)
                            begin
                                row_next = row_reg - ROW_W'(1);
                                col_next = COL_W'(COLS - 1);
                            end
                        end
                        else if (wrap)
                        begin
                            col_next = '0;
                            row_next = row_over ? ROW_W'(ROWS - 1) : row_inc;
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        row_next = '0;
                        col_next = '0;
                    end
                    CMD_SET_CURSOR:
                    begin
                        row_next = (item_reg.row_pos < ROW_W'(ROWS)) ?
                                   item_reg.row_pos : ROW_W'(ROWS - 1);
                        col_next = (item_reg.col_pos < COL_W'(COLS)) ?
                                   item_reg.col_pos : COL_W'(COLS - 1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_READ:
            begin
                if (pos_ok)
                begin
                    rd_char_next = rdata[7:0];
                    rd_attr_next = rdata[15:8];
                end
            end
            ST_SCROLL:
            begin
                copy_pend_next = 1'b1;
                ptr_next       = ptr_reg + ADDR_W'(1);
            end
            ST_BLANK:
            begin
                if (!copy_pend_reg && !ptr_last)
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // A copied cell is written in the cycle after its read, ahead of any other write.
    always_comb
    begin
        mem_ctl.we    = 1'b0;
        mem_ctl.waddr = copy_addr_reg;
        mem_ctl.wdata = rdata;
        mem_ctl.raddr = (state_reg == ST_SCROLL) ? ptr_reg + ADDR_W'(COLS) : unit_addr;
        if (copy_pend_reg)
        begin
            mem_ctl.we = 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_INIT:
                begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = ptr_reg;
                    mem_ctl.wdata = {RESET_ATTR, CHAR_BLANK};
                end
                ST_BLANK:
                begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = ptr_reg;
                    mem_ctl.wdata = {attr_reg, CHAR_BLANK};
                end
                ST_BSWR:
                begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = unit_addr;
                    mem_ctl.wdata = {attr_reg, CHAR_BLANK};
                end
                ST_EXEC:
                begin
                    mem_ctl.waddr = unit_addr;
                    if (item_reg.cmd == CMD_PUT_CHAR && !is_nl && !is_bs)
                    begin
                        mem_ctl.we    = 1'b1;
                        mem_ctl.wdata = {attr_reg, item_reg.char_code};
                    end
                    else if (item_reg.cmd == CMD_PUT_CELL && pos_ok)
                    begin
                        mem_ctl.we    = 1'b1;
                        mem_ctl.wdata = {item_reg.cell_attr, item_reg.char_code};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        item_ready          = (state_reg == ST_IDLE);
        cfg_ready           = (state_reg == ST_IDLE);
        result_valid        = (state_reg == ST_OUT_CR) || (state_reg == ST_OUT);
        result.row_after    = row_reg;
        result.col_after    = col_reg;
        result.read_char    = rd_char_reg;
        result.read_attr    = rd_attr_reg;
        result.serial_valid = 1'b0;
        result.serial_byte  = '0;
        result.last         = 1'b1;
        if (state_reg == ST_OUT_CR)
        begin
            result.serial_valid = 1'b1;
            result.serial_byte  = CHAR_CR;
            result.last         = 1'b0;
        end
        else if (item_reg.cmd == CMD_PUT_CHAR && !is_bs)
        begin
            result.serial_valid = 1'b1;
            result.serial_byte  = item_reg.char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            attr_reg      <= RESET_ATTR;
            row_reg       <= '0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            copy_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            copy_pend_reg <= copy_pend_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        copy_addr_reg <= copy_addr_next;
        rd_char_reg   <= rd_char_next;
        rd_attr_reg   <= rd_attr_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(result_valid && item_ready))
        else $error("Result offered while a new word is taken.");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < ROW_W'(ROWS)) && (col_reg < COL_W'(COLS)))
        else $error("Cursor left the screen.");

    a_copy_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        copy_pend_reg |-> $past(state_reg == ST_SCROLL))
        else $error("Cell copy without a scroll read.");

    a_cr_then_nl: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !result.last) |=>
        (result_valid && result.last && result.serial_byte == CHAR_NL))
        else $error("Carriage return not followed by newline.");

endmodule

// ===== rtl/tcw_screen_mem.sv =====
// Screen cell store: one write port and one registered read port.
module tcw_screen_mem import tcw_pkg::*; (
    input  logic        clk,
    input  mem_ctl_t    ctl,
    output logic [15:0] rdata
);

    logic [15:0] cells_mem [CELLS];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            cells_mem[ctl.waddr] <= ctl.wdata;
        end
        rdata_reg <= cells_mem[ctl.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/text_console_writer_tb.sv =====
// Self-checking testbench for the text console writer: random and directed commands, scored words.
module text_console_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
    localparam int PHASE_ITEMS  = 190;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 50;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_ready;
    item_t      item_word    = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result_word;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data     = '0;

    item_t      pending_items[$];
    result_t    status_expected[$];
    result_t    want;

    logic [15:0] screen_model[CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  text_attr_model;

    bit item_taken;
    bit calm_mode;
    bit hold_req;
    bit hold_served;
    int send_gap;
    int take_gap;
    int hold_cycles;
    int fail_count;
    int items_taken;
    int words_checked;
    int scroll_count;
    int clear_count;
    int attr_writes;

    text_console_writer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void blank_screen(input logic [7:0] attr);
        for (int k = 0; k < CELLS; k++)
            screen_model[k] = {attr, CHAR_BLANK};
    endfunction

    function automatic void queue_status(input logic sv, input logic [7:0] sb, input logic lst,
                                         input logic [7:0] rc, input logic [7:0] ra);
        result_t w;
        w.serial_valid = sv;
        w.serial_byte  = sb;
        w.last         = lst;
        w.row_after    = cur_row[ROW_W-1:0];
        w.col_after    = cur_col[COL_W-1:0];
        w.read_char    = rc;
        w.read_attr    = ra;
        status_expected.push_back(w);
    endfunction

    function automatic void predict_console(input item_t it);
        int         r;
        int         c;
        bit         in_range;
        logic [7:0] rd_char;
        logic [7:0] rd_attr;
        r        = int'(it.row_pos);
        c        = int'(it.col_pos);
        in_range = (r < ROWS) && (c < COLS);
        rd_char  = '0;
        rd_attr  = '0;
        case (it.cmd)
            CMD_PUT_CHAR:
            begin
                if (it.char_code == CHAR_NL)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (it.char_code == CHAR_BS)
                begin
                    if (cur_col > 0)
                        cur_col--;
                    else if (cur_row > 0)
                    begin
                        cur_row--;
                        cur_col = COLS - 1;
                    end
                    screen_model[cur_row * COLS + cur_col] = {text_attr_model, CHAR_BLANK};
                end
                else
                begin
                    screen_model[cur_row * COLS + cur_col] = {text_attr_model, it.char_code};
                    cur_col++;
                    if (cur_col >= COLS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                if (cur_row >= ROWS)
                begin
                    for (int k = 0; k < (ROWS - 1) * COLS; k++)
                        screen_model[k] = screen_model[k + COLS];
                    for (int k = (ROWS - 1) * COLS; k < CELLS; k++)
                        screen_model[k] = {text_attr_model, CHAR_BLANK};
                    cur_row = ROWS - 1;
                    scroll_count++;
                end
                if (it.char_code == CHAR_NL)
                begin
                    queue_status(1'b1, CHAR_CR, 1'b0, '0, '0);
                    queue_status(1'b1, CHAR_NL, 1'b1, '0, '0);
                end
                else if (it.char_code == CHAR_BS)
                    queue_status(1'b0, '0, 1'b1, '0, '0);
                else
                    queue_status(1'b1, it.char_code, 1'b1, '0, '0);
            end
            CMD_CLEAR:
            begin
                blank_screen(text_attr_model);
                cur_row = 0;
                cur_col = 0;
                clear_count++;
            end
            CMD_SET_CURSOR:
            begin
                cur_row = (r < ROWS) ? r : ROWS - 1;
                cur_col = (c < COLS) ? c : COLS - 1;
            end
            CMD_PUT_CELL:
            begin
                if (in_range)
                    screen_model[r * COLS + c] = {it.cell_attr, it.char_code};
            end
            CMD_READ_CELL:
            begin
                if (in_range)
                    {rd_attr, rd_char} = screen_model[r * COLS + c];
            end
            default:
            begin
            end
        endcase
        if (it.cmd != CMD_PUT_CHAR)
            queue_status(1'b0, '0, 1'b1, rd_char, rd_attr);
    endfunction

    function automatic item_t make_item(input logic [2:0] cmd, input logic [7:0] ch,
                                        input logic [4:0] r, input logic [6:0] c,
                                        input logic [7:0] attr);
        item_t it;
        it.cmd       = cmd;
        it.char_code = ch;
        it.row_pos   = r;
        it.col_pos   = c;
        it.cell_attr = attr;
        return it;
    endfunction

    function automatic item_t random_command();
        item_t it;
        int    pick;
        pick         = $urandom_range(0, 99);
        it.char_code = 8'($urandom_range(0, 255));
        it.cell_attr = 8'($urandom_range(0, 255));
        it.row_pos   = ROW_W'($urandom_range(0, 31));
        it.col_pos   = COL_W'($urandom_range(0, 127));
        if (pick >= 55 && pick < 96 && $urandom_range(0, 7) != 0)
        begin
            it.row_pos = ROW_W'($urandom_range(0, ROWS - 1));
            it.col_pos = COL_W'($urandom_range(0, COLS - 1));
        end
        if (pick < 55)
        begin
            it.cmd = CMD_PUT_CHAR;
            case ($urandom_range(0, 9))
                0: it.char_code = CHAR_NL;
                1: it.char_code = CHAR_BS;
                default:
                begin
                end
            endcase
        end
        else if (pick < 57)
            it.cmd = CMD_CLEAR;
        else if (pick < 70)
        begin
            it.cmd = CMD_SET_CURSOR;
            if ($urandom_range(0, 1) == 0)
            begin
                it.row_pos = ROW_W'($urandom_range(ROWS - 5, ROWS - 1));
                it.col_pos = COL_W'($urandom_range(COLS - 8, COLS - 1));
            end
        end
        else if (pick < 82)
            it.cmd = CMD_PUT_CELL;
        else if (pick < 96)
            it.cmd = CMD_READ_CELL;
        else
            it.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    task automatic wait_quiet();
        @(posedge clk);
        while (pending_items.size() != 0 || item_valid || status_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    // Command driver.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (item_taken && !calm_mode && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 6);
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_word  <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Result receiver with random stalls and one long hold-off.
    always @(negedge clk)
    begin
        if (hold_req && !hold_served)
        begin
            result_ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= LONG_HOLD)
                hold_served = 1'b1;
        end
        else if (take_gap > 0)
        begin
            take_gap--;
            result_ready <= 1'b0;
        end
        else if (!calm_mode && $urandom_range(0, 4) == 0)
        begin
            take_gap = $urandom_range(0, 5);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // Monitor and scoreboard.
    always @(posedge clk)
    begin
        if (!rst_n)
            item_taken = 1'b0;
        else
        begin
            item_taken = item_valid && item_ready;
            if (item_taken)
            begin
                items_taken++;
                predict_console(item_word);
            end
            if (cfg_valid && cfg_ready)
                text_attr_model = cfg_data;
            if (result_valid && result_ready)
            begin
                if (status_expected.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = status_expected.pop_front();
                    check_field("serial_valid", 32'(want.serial_valid),
                                32'(result_word.serial_valid));
                    check_field("serial_byte", 32'(want.serial_byte),
                                32'(result_word.serial_byte));
                    check_field("last", 32'(want.last), 32'(result_word.last));
                    check_field("row_after", 32'(want.row_after),
                                32'(result_word.row_after));
                    check_field("col_after", 32'(want.col_after),
                                32'(result_word.col_after));
                    check_field("read_char", 32'(want.read_char),
                                32'(result_word.read_char));
                    check_field("read_attr", 32'(want.read_attr),
                                32'(result_word.read_attr));
                    words_checked++;
                end
            end
        end
    end

    initial
    begin
        blank_screen(RESET_ATTR);
        cur_row         = 0;
        cur_col         = 0;
        text_attr_model = RESET_ATTR;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        pending_items.push_back(make_item(CMD_PUT_CHAR, 8'h41, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_PUT_CHAR, 8'hFF, 5'd31, 7'd127, 8'hFF));
        pending_items.push_back(make_item(CMD_PUT_CHAR, 8'h00, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_PUT_CHAR, 8'h80, 5'd16, 7'd64, 8'h80));
        pending_items.push_back(make_item(CMD_PUT_CHAR, CHAR_BS, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_PUT_CHAR, CHAR_NL, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_PUT_CHAR, CHAR_BS, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_SET_CURSOR, 8'h00, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_PUT_CHAR, CHAR_BS, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_SET_CURSOR, 8'hFF, 5'd31, 7'd127, 8'hFF));
        pending_items.push_back(make_item(CMD_PUT_CHAR, 8'h7E, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_PUT_CHAR, CHAR_NL, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_PUT_CELL, 8'h55, 5'd24, 7'd79, 8'hAA));
        pending_items.push_back(make_item(CMD_PUT_CELL, 8'hAA, 5'd0, 7'd0, 8'h55));
        pending_items.push_back(make_item(CMD_PUT_CELL, 8'h11, 5'd25, 7'd0, 8'hFF));
        pending_items.push_back(make_item(CMD_PUT_CELL, 8'h22, 5'd0, 7'd80, 8'h00));
        pending_items.push_back(make_item(CMD_READ_CELL, 8'h00, 5'd24, 7'd79, 8'h00));
        pending_items.push_back(make_item(CMD_READ_CELL, 8'hFF, 5'd0, 7'd0, 8'hFF));
        pending_items.push_back(make_item(CMD_READ_CELL, 8'h00, 5'd25, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_READ_CELL, 8'h00, 5'd31, 7'd127, 8'h00));
        pending_items.push_back(make_item(CMD_UNUSED_FIRST, 8'hFF, 5'd31, 7'd127, 8'hFF));
        pending_items.push_back(make_item(CMD_UNUSED_FIRST + 3'd1, 8'h0A, 5'd3, 7'd3, 8'h33));
        pending_items.push_back(make_item(CMD_UNUSED_LAST, 8'h08, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00));
        pending_items.push_back(make_item(CMD_READ_CELL, 8'h00, 5'd12, 7'd40, 8'h00));
        wait_quiet();

        write_attribute(8'hFF);
        repeat (PHASE_ITEMS) pending_items.push_back(random_command());
        wait_quiet();

        write_attribute(8'h00);
        hold_req = 1'b1;
        repeat (PHASE_ITEMS) pending_items.push_back(random_command());
        wait_quiet();

        write_attribute(8'($urandom_range(0, 255)));
        repeat (PHASE_ITEMS) pending_items.push_back(random_command());
        wait_quiet();

        write_attribute(8'($urandom_range(0, 255)));
        repeat (PHASE_ITEMS) pending_items.push_back(random_command());
        wait_quiet();

        write_attribute(RESET_ATTR);
        calm_mode = 1'b1;
        repeat (PHASE_ITEMS) pending_items.push_back(random_command());
        wait_quiet();

        $display("Ran %0d commands giving %0d result words, with %0d scrolls and %0d clears,",
                 items_taken, words_checked, scroll_count, clear_count);
        $display("under %0d attribute settings and one %0d-cycle result hold-off.",
                 attr_writes + 1, LONG_HOLD);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

endmodule
